>>> rtl/imm_pkg.sv
// Shared types and constants of the integer matrix multiply unit.
// Used by the front end, the command queue, the back end and the top level.
// Depends on nothing else.
package imm_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_DIM    = 8;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Fixed field widths of the stream words and the configuration port.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - SUM_W - 2 * IDX_W;

  // Depth of the queue between the front end and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Command codes carried in tuser of an input word.
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  // Operations that the front end hands to the back end.
  localparam int unsigned OP_W = 2;
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE
  } op_e;

  // One result element as the back end presents it.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic             last;
  } result_t;

endpackage

>>> rtl/imm_front.sv
// Front end of the integer matrix multiply unit: accepts input words,
// assigns store addresses to loads and drops loads past the matrix size.
// Depends on imm_pkg.
module imm_front import imm_pkg::*; #(
  parameter int unsigned MAX_DIM    = DEF_MAX_DIM,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int unsigned CNT_W     = $clog2(MAX_DIM + 1),
  localparam int unsigned ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CNT_W-1:0]         rows_i,
  input  logic [CNT_W-1:0]         inner_i,
  input  logic [CNT_W-1:0]         cols_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [ELEM_W-1:0] elem_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output op_e                      q_kind_o,
  output logic [ADDR_W-1:0]        q_addr_o,
  output logic [DATA_WIDTH-1:0]    q_data_o
);

  localparam int unsigned CELLS  = MAX_DIM * MAX_DIM;
  localparam int unsigned FILL_W = $clog2(CELLS + 1);

  logic [FILL_W-1:0] fill_a_q, fill_a_d;
  logic [FILL_W-1:0] fill_b_q, fill_b_d;
  logic [FILL_W-1:0] size_a, size_b;
  logic              accept;

  // A word is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign size_a = FILL_W'(rows_i) * FILL_W'(inner_i);
  assign size_b = FILL_W'(inner_i) * FILL_W'(cols_i);

  // The element is stored at the data width, sign-extended or truncated.
  assign q_data_o = DATA_WIDTH'(elem_i);

  // Classify the word and advance or rewind the load pointers.
  always_comb begin
    q_push_o = 1'b0;
    q_kind_o = OP_LOAD_A;
    q_addr_o = fill_a_q[ADDR_W-1:0];
    fill_a_d = fill_a_q;
    fill_b_d = fill_b_q;
    if (accept) begin
      unique case (cmd_i)
        CMD_LOAD_A: begin
          if (fill_a_q < size_a) begin
            q_push_o = 1'b1;
            fill_a_d = fill_a_q + FILL_W'(1);
          end
        end
        CMD_LOAD_B: begin
          q_kind_o = OP_LOAD_B;
          q_addr_o = fill_b_q[ADDR_W-1:0];
          if (fill_b_q < size_b) begin
            q_push_o = 1'b1;
            fill_b_d = fill_b_q + FILL_W'(1);
          end
        end
        CMD_COMPUTE: begin
          q_kind_o = OP_COMPUTE;
          q_push_o = 1'b1;
          fill_a_d = '0;
          fill_b_d = '0;
        end
        default: begin
          // The unused command is dropped here.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_a_q <= '0;
      fill_b_q <= '0;
    end else begin
      fill_a_q <= fill_a_d;
      fill_b_q <= fill_b_d;
    end
  end

endmodule

>>> rtl/imm_queue.sv
// Short first-in first-out queue of operations between the front end and
// the back end of the integer matrix multiply unit. Depends on imm_pkg.
module imm_queue import imm_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slots_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/imm_back.sv
// Back end of the integer matrix multiply unit: the two element stores, the
// shared multiply-accumulate pipeline and the result register.
// Depends on imm_pkg.
module imm_back import imm_pkg::*; #(
  parameter int unsigned MAX_DIM    = DEF_MAX_DIM,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int unsigned CNT_W     = $clog2(MAX_DIM + 1),
  localparam int unsigned ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CNT_W-1:0]      rows_i,
  input  logic [CNT_W-1:0]      inner_i,
  input  logic [CNT_W-1:0]      cols_i,
  input  logic                  q_valid_i,
  input  op_e                   q_kind_i,
  input  logic [ADDR_W-1:0]     q_addr_i,
  input  logic [DATA_WIDTH-1:0] q_data_i,
  output logic                  q_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o
);

  localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
  localparam int unsigned DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WAIT,
    B_ISSUE,
    B_DRAIN
  } state_e;

  state_e state_q;

  logic [DATA_WIDTH-1:0]     mem_a [CELLS];
  logic [DATA_WIDTH-1:0]     mem_b [CELLS];
  logic [DATA_WIDTH-1:0]     rd_a_q, rd_b_q;
  logic signed [ELEM_W-1:0]  op_a, op_b;
  logic signed [2*ELEM_W-1:0] prod_full;
  logic [DATA_WIDTH-1:0]     prod_q, acc_q, acc_sum;

  logic [DIM_W-1:0]  i_q, j_q, k_q;
  logic [ADDR_W-1:0] row_base_q, a_addr_q, b_addr_q;
  logic              v1_q, v2_q, first1_q, first2_q, last1_q, last2_q;
  logic              res_valid_q;
  result_t           res_q;

  logic we_a, we_b, start, rd_en;
  logic i_last, j_last, k_last, done, out_take;

  // Operation decode at the head of the queue.
  assign q_pop_o  = (state_q == B_IDLE) && q_valid_i;
  assign we_a     = q_pop_o && (q_kind_i == OP_LOAD_A);
  assign we_b     = q_pop_o && (q_kind_i == OP_LOAD_B);
  assign start    = q_pop_o && (q_kind_i == OP_COMPUTE);
  assign rd_en    = (state_q == B_ISSUE);

  assign i_last   = (i_q == DIM_W'(rows_i - CNT_W'(1)));
  assign j_last   = (j_q == DIM_W'(cols_i - CNT_W'(1)));
  assign k_last   = (k_q == DIM_W'(inner_i - CNT_W'(1)));
  assign done     = v2_q && last2_q;
  assign out_take = res_valid_q && res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Element stores, one write or one read per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[q_addr_i] <= q_data_i;
    end
    if (we_b) begin
      mem_b[q_addr_i] <= q_data_i;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[a_addr_q];
      rd_b_q <= mem_b[b_addr_q];
    end
  end

  // Operands are the low 32 bits of a stored element, taken as signed; a narrower element is zero-extended.
  if (DATA_WIDTH >= ELEM_W) begin : g_wide
    assign op_a = $signed(rd_a_q[ELEM_W-1:0]);
    assign op_b = $signed(rd_b_q[ELEM_W-1:0]);
  end else begin : g_narrow
    assign op_a = $signed(ELEM_W'(rd_a_q));
    assign op_b = $signed(ELEM_W'(rd_b_q));
  end

  assign prod_full = op_a * op_b;

  // The first product of a dot product starts a fresh sum.
  assign acc_sum = (first2_q ? '0 : acc_q) + prod_q;

  // Multiply and accumulate datapath.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= DATA_WIDTH'(prod_full);
    end
    if (v2_q) begin
      acc_q <= acc_sum;
    end
  end

  // Sequencer over the result elements and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      row_base_q  <= '0;
      a_addr_q    <= '0;
      b_addr_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      first1_q    <= 1'b0;
      first2_q    <= 1'b0;
      last1_q     <= 1'b0;
      last2_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      v1_q     <= rd_en;
      first1_q <= (k_q == '0);
      last1_q  <= k_last;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;

      if (out_take) begin
        res_valid_q <= 1'b0;
      end
      if (done) begin
        res_valid_q   <= 1'b1;
        res_q.sum     <= SUM_W'(acc_sum);
        res_q.row     <= IDX_W'(i_q);
        res_q.column  <= IDX_W'(j_q);
        res_q.last    <= i_last && j_last;
      end

      unique case (state_q)
        B_IDLE: begin
          if (start) begin
            i_q        <= '0;
            j_q        <= '0;
            row_base_q <= '0;
            state_q    <= B_WAIT;
          end
        end
        B_WAIT: begin
          // Start the next element once the result register is free.
          if (!res_valid_q) begin
            k_q      <= '0;
            a_addr_q <= row_base_q;
            b_addr_q <= ADDR_W'(j_q);
            state_q  <= B_ISSUE;
          end
        end
        B_ISSUE: begin
          k_q      <= k_q + DIM_W'(1);
          a_addr_q <= a_addr_q + ADDR_W'(1);
          b_addr_q <= b_addr_q + ADDR_W'(cols_i);
          if (k_last) begin
            state_q <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (done) begin
            if (i_last && j_last) begin
              state_q <= B_IDLE;
            end else begin
              if (j_last) begin
                j_q        <= '0;
                i_q        <= i_q + DIM_W'(1);
                row_base_q <= row_base_q + ADDR_W'(inner_i);
              end else begin
                j_q <= j_q + DIM_W'(1);
              end
              state_q <= B_WAIT;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((we_a || we_b) && rd_en))
    else $error("store written while a dot product reads it");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == B_DRAIN))
    else $error("dot product finished outside the drain state");

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !res_valid_q)
    else $error("result overwrites a word not yet taken");

  a_res_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == B_DRAIN))
    else $error("result raised without a finished dot product");
`endif

endmodule

>>> rtl/integer_matrix_multiply_unit.sv
// Top level of the integer matrix multiply unit: configuration registers and
// the stream ports around the front end, the queue and the back end.
// Depends on imm_pkg, imm_front, imm_queue and imm_back.

// The unit loads signed elements of A and of B in row-major order
// (command 0 and 1 in tuser), and on command 2 streams out every element of
// C = A x B in row-major order with tlast on the final one; sums wrap to the
// data width and are shown as 32 bits. Dimensions come from three 4-bit
// registers; 0 acts as 1 and values above MAX_DIM act as MAX_DIM. Loads past
// the configured size and command 3 are dropped. A load word is taken
// whenever the queue has room. For a compute word, a single
// multiply-accumulate unit reads one element of each store per cycle
// and one result element is formed at a time. A four-entry queue sits
// between input and compute, so input words keep flowing while the result
// stream is stalled, until the queue fills.
module integer_matrix_multiply_unit import imm_pkg::*; #(
  parameter int unsigned MAX_DIM    = DEF_MAX_DIM,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [ELEM_W-1:0]      s_axis_tdata_i,   // [31:0] element
  input  logic [CMD_W-1:0]       s_axis_tuser_i,   // [1:0] command
  // Result stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [31:0] sum, [34:32] row,
                                                   // [37:35] column, zero pad
  output logic                   m_axis_tlast_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int unsigned ENTRY_W = OP_W + ADDR_W + DATA_WIDTH;

  logic [CNT_W-1:0]      rows_q, inner_q, cols_q;
  logic                  q_push, q_full, q_empty, q_pop;
  op_e                   push_kind, head_kind;
  logic [ADDR_W-1:0]     push_addr, head_addr;
  logic [DATA_WIDTH-1:0] push_data, head_data;
  logic [ENTRY_W-1:0]    push_entry, head_entry;
  result_t               res;

  // Clamp a written dimension into one to MAX_DIM.
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [CNT_W-1:0] res_dim;
    if (v == '0) begin
      res_dim = CNT_W'(1);
    end else if (v > CFG_DATA_W'(MAX_DIM)) begin
      res_dim = CNT_W'(MAX_DIM);
    end else begin
      res_dim = CNT_W'(v);
    end
    return res_dim;
  endfunction

  // Dimension registers hold the clamped value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CNT_W'(1);
      inner_q <= CNT_W'(1);
      cols_q  <= CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROWS_A:     rows_q  <= clamp_dim(cfg_wdata_i);
        REG_INNER_SIZE: inner_q <= clamp_dim(cfg_wdata_i);
        REG_COLS_B:     cols_q  <= clamp_dim(cfg_wdata_i);
        default: begin
          // Unknown index: the write is ignored.
        end
      endcase
    end
  end

  imm_front #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rows_i     (rows_q),
    .inner_i    (inner_q),
    .cols_i     (cols_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .elem_i     ($signed(s_axis_tdata_i)),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_kind_o   (push_kind),
    .q_addr_o   (push_addr),
    .q_data_o   (push_data)
  );

  // Queue entries carry the operation, the store address and the element.
  assign push_entry = {push_kind, push_addr, push_data};
  assign head_kind  = op_e'(head_entry[ENTRY_W-1 -: OP_W]);
  assign head_addr  = head_entry[DATA_WIDTH +: ADDR_W];
  assign head_data  = head_entry[DATA_WIDTH-1:0];

  imm_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head_entry),
    .empty_o     (q_empty)
  );

  imm_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_q),
    .inner_i     (inner_q),
    .cols_i      (cols_q),
    .q_valid_i   (!q_empty),
    .q_kind_i    (head_kind),
    .q_addr_i    (head_addr),
    .q_data_i    (head_data),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Result word packing.
  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, res.column, res.row, res.sum};
  assign m_axis_tlast_o = res.last;

endmodule

>>> verif/integer_matrix_multiply_unit_tb.sv
// Self-checking testbench for integer_matrix_multiply_unit: streams load and
// compute words, predicts every element of C = A x B and checks each result word.
// Depends on imm_pkg and the RTL of the unit; reads no files.
module integer_matrix_multiply_unit_tb;
  import imm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed.
  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_WORDS   = 370;
  localparam int SETTLE_CYCLES  = 50;
  localparam int LONG_HOLD      = 2000;
  // The slowest correct gap between accepted words is the long receiver hold.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] elem;
  } in_word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [ELEM_W-1:0]      s_axis_tdata_i = '0;
  logic [CMD_W-1:0]       s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  integer_matrix_multiply_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Words waiting to be sent and elements of C waiting to come out.
  in_word_t pending_words[$];
  result_t  expected_elems[$];
  in_word_t next_word;

  // Predicted state of the unit: register copies, element stores, load pointers.
  logic [CFG_DATA_W-1:0] dim_reg[3];
  logic [ELEM_W-1:0]     a_elems[64];
  logic [ELEM_W-1:0]     b_elems[64];
  int                    a_fill;
  int                    b_fill;

  // Planning view of the load pointers and how far each store has been written.
  int plan_ptr_a;
  int plan_ptr_b;
  int written_a;
  int written_b;
  int useful_words;

  int  error_count;
  int  send_wait;
  int  recv_wait;
  int  hold_left;
  int  quiet_cycles;
  bit  send_burst;
  bit  recv_burst;
  bit  stall_request;

  // A register value of 0 acts as 1, values above 8 act as 8.
  function automatic int dim(input int idx);
    if (dim_reg[idx] == 0) return 1;
    if (dim_reg[idx] > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(dim_reg[idx]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Apply one accepted word to the predicted state and queue the elements it causes.
  task automatic predict_word(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] elem);
    int m;
    int n;
    int p;
    logic [SUM_W-1:0] acc;
    result_t r;
    m = dim(0);
    n = dim(1);
    p = dim(2);
    case (cmd)
      CMD_LOAD_A: begin
        if (a_fill < m * n) begin
          a_elems[a_fill] = elem;
          a_fill++;
        end
      end
      CMD_LOAD_B: begin
        if (b_fill < n * p) begin
          b_elems[b_fill] = elem;
          b_fill++;
        end
      end
      CMD_COMPUTE: begin
        a_fill = 0;
        b_fill = 0;
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
              acc = acc + a_elems[i * n + k] * b_elems[k * p + j];
            end
            r.sum    = acc;
            r.row    = IDX_W'(i);
            r.column = IDX_W'(j);
            r.last   = (i == m - 1) && (j == p - 1);
            expected_elems.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compare one result word with the oldest expected element.
  task automatic check_element(input logic [OUT_TDATA_W-1:0] data, input logic tlast);
    result_t want;
    if (expected_elems.size() == 0) begin
      report_mismatch("unexpected result word", data[SUM_W-1:0], '0);
      return;
    end
    want = expected_elems.pop_front();
    if (data[SUM_W-1:0] !== want.sum)
      report_mismatch("sum", data[SUM_W-1:0], want.sum);
    if (data[SUM_W +: IDX_W] !== want.row)
      report_mismatch("row", 32'(data[SUM_W +: IDX_W]), 32'(want.row));
    if (data[SUM_W + IDX_W +: IDX_W] !== want.column)
      report_mismatch("column", 32'(data[SUM_W + IDX_W +: IDX_W]), 32'(want.column));
    if (data[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
      report_mismatch("tdata padding", 32'(data[OUT_TDATA_W-1 -: OUT_PAD_W]), '0);
    if (tlast !== want.last)
      report_mismatch("tlast", 32'(tlast), 32'(want.last));
  endtask

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: offers queued words with a random gap after each accepted word, or none in burst mode.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      send_wait       <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_word(s_axis_tuser_i, s_axis_tdata_i);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_wait != 0) begin
          send_wait       <= send_wait - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= next_word.elem;
          s_axis_tuser_i  <= next_word.cmd;
          send_wait       <= send_burst ? 0 : $urandom_range(0, 9);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted word, stalls at random and on request for a long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_element(m_axis_tdata_o, m_axis_tlast_o);
        recv_wait = recv_burst ? 0 : $urandom_range(0, 9);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      if (stall_request) begin
        hold_left     = LONG_HOLD;
        stall_request = 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      m_axis_tready_i <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("integer_matrix_multiply_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Queue one word and track where the load pointers will stand.
  task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] elem);
    in_word_t w;
    w.cmd  = cmd;
    w.elem = elem;
    pending_words.push_back(w);
    case (cmd)
      CMD_LOAD_A: begin
        if (plan_ptr_a < dim(0) * dim(1)) begin
          plan_ptr_a++;
          if (plan_ptr_a > written_a) written_a = plan_ptr_a;
          useful_words++;
        end
      end
      CMD_LOAD_B: begin
        if (plan_ptr_b < dim(1) * dim(2)) begin
          plan_ptr_b++;
          if (plan_ptr_b > written_b) written_b = plan_ptr_b;
          useful_words++;
        end
      end
      CMD_COMPUTE: begin
        plan_ptr_a = 0;
        plan_ptr_b = 0;
        useful_words++;
      end
      default: ;
    endcase
  endtask

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return ELEM_W'(int'($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  // Load both matrices, sometimes short, sometimes past size, with stray
  // unused commands, then compute. Entries never written are never read.
  task automatic queue_product();
    int size_a;
    int size_b;
    int loads_a;
    int loads_b;
    size_a  = dim(0) * dim(1);
    size_b  = dim(1) * dim(2);
    loads_a = (size_a > plan_ptr_a) ? size_a - plan_ptr_a : 0;
    loads_b = (size_b > plan_ptr_b) ? size_b - plan_ptr_b : 0;
    case ($urandom_range(0, 9))
      7: begin
        loads_a += $urandom_range(1, 3);
        loads_b += $urandom_range(1, 3);
      end
      8, 9: begin
        loads_a = $urandom_range(0, loads_a);
        loads_b = $urandom_range(0, loads_b);
      end
      default: ;
    endcase
    while (loads_a + loads_b != 0) begin
      if ($urandom_range(0, 15) == 0) queue_word(CMD_UNUSED, pick_element());
      if (loads_b == 0 || (loads_a != 0 && $urandom_range(0, 1) == 0)) begin
        queue_word(CMD_LOAD_A, pick_element());
        loads_a--;
      end else begin
        queue_word(CMD_LOAD_B, pick_element());
        loads_b--;
      end
    end
    while (written_a < size_a) queue_word(CMD_LOAD_A, pick_element());
    while (written_b < size_b) queue_word(CMD_LOAD_B, pick_element());
    queue_word(CMD_COMPUTE, pick_element());
  endtask

  // Register write over one cycle; only issued while the unit is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ROWS_A:     dim_reg[0] = val;
      REG_INNER_SIZE: dim_reg[1] = val;
      REG_COLS_B:     dim_reg[2] = val;
      default: ;
    endcase
  endtask

  // Wait until every word is sent and every element is out, then let queued
  // loads, which cause no result, drain. The check runs at the falling edge,
  // after the sender and receiver have settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || s_axis_tvalid_i || expected_elems.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(9, 15));
      2: return CFG_DATA_W'(DEF_MAX_DIM);
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Stimulus: directed cases, then random phases with their own dimensions.
  initial begin
    int phase;
    int goal;
    logic [CFG_DATA_W-1:0] raw[3];
    dim_reg      = '{4'd1, 4'd1, 4'd1};
    a_fill       = 0;
    b_fill       = 0;
    plan_ptr_a   = 0;
    plan_ptr_b   = 0;
    written_a    = 0;
    written_b    = 0;
    useful_words = 0;
    error_count  = 0;
    quiet_cycles = 0;
    send_burst   = 1'b0;
    recv_burst   = 1'b0;
    stall_request = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 at reset dimensions: the product of the largest values, the product of the
    // most negative values, a load past size and an unused command.
    queue_word(CMD_LOAD_A, 32'h7FFF_FFFF);
    queue_word(CMD_LOAD_B, 32'h7FFF_FFFF);
    queue_word(CMD_COMPUTE, '0);
    queue_word(CMD_LOAD_A, 32'h8000_0000);
    queue_word(CMD_LOAD_A, 32'h1234_5678);
    queue_word(CMD_LOAD_B, 32'h8000_0000);
    queue_word(CMD_UNUSED, '1);
    queue_word(CMD_COMPUTE, '1);
    wait_idle();

    // Out-of-range register values clamp; the unknown index is ignored.
    write_reg(REG_UNUSED, '1);
    write_reg(REG_ROWS_A, '1);
    write_reg(REG_INNER_SIZE, '0);
    write_reg(REG_COLS_B, 4'd1);
    queue_word(CMD_LOAD_A, '1);
    queue_word(CMD_LOAD_A, 32'h8000_0000);
    queue_word(CMD_LOAD_A, 32'h7FFF_FFFF);
    queue_word(CMD_LOAD_A, '0);
    queue_word(CMD_LOAD_A, 32'd1);
    queue_word(CMD_LOAD_A, 32'hAAAA_AAAA);
    queue_word(CMD_LOAD_A, 32'h5555_5555);
    queue_word(CMD_LOAD_A, 32'd2);
    queue_word(CMD_LOAD_B, '1);
    queue_word(CMD_COMPUTE, '0);
    wait_idle();

    // The three directed phases always run, then random ones until the goal.
    goal  = useful_words + RANDOM_WORDS;
    phase = 0;
    while (useful_words < goal || phase < 3) begin
      case (phase)
        0: raw = '{4'd8, 4'd8, 4'd8};
        1: raw = '{4'd15, 4'd0, 4'd15};
        2: raw = '{4'd3, 4'd3, 4'd3};
        default: raw = '{pick_dim_raw(), pick_dim_raw(), pick_dim_raw()};
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
      write_reg(REG_ROWS_A, raw[0]);
      write_reg(REG_INNER_SIZE, raw[1]);
      write_reg(REG_COLS_B, raw[2]);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Hold the result side off while words keep coming, so the queue fills.
        send_burst    = 1'b1;
        stall_request = 1'b1;
        repeat (6) queue_product();
      end else if (phase == 0) begin
        // One full-size product keeps the word count near the goal.
        queue_product();
      end else begin
        repeat ($urandom_range(1, 4)) queue_product();
      end
      // Stray loads leave the pointers away from zero across the next register change.
      repeat ($urandom_range(0, 3)) begin
        queue_word($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B, pick_element());
      end
      wait_idle();
      phase++;
    end

    if (error_count == 0) begin
      $display("integer_matrix_multiply_unit regression: pass");
    end else begin
      $display("integer_matrix_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule
